### hdl/rau_pkg.sv
// Shared types and constants for the rational arithmetic unit.
package rau_pkg;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    // Width of the full-precision intermediates (two 32-bit magnitudes multiplied, plus carry)
    localparam int WIDE = 65;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_COMB,
        S_GCD_START,
        S_GCD_DIV,
        S_GCD_STEP,
        S_RED_NUM,
        S_RED_DEN,
        S_CHECK
    } state_t;

    // Request/status between the sequencer and the shared divider
    typedef struct packed {
        logic             start;
        logic [WIDE-1:0]  dividend;
        logic [WIDE-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [WIDE-1:0]  quotient;
        logic [WIDE-1:0]  remainder;
    } div_rsp_t;

endpackage

### hdl/rau_divider.sv
// Restoring divider, one quotient bit per cycle.
module rau_divider
(
    input  logic              clk,
    input  logic              rst_n,
    input  rau_pkg::div_req_t req,
    output rau_pkg::div_rsp_t rsp
);

    localparam int W  = rau_pkg::WIDE;
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;
    logic [W:0]    shifted;

    // One shift-and-subtract step
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quo_reg[W-1]};
        trial     = shifted - {1'b0, dvs_reg};
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[W])
            begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

### hdl/rational_arithmetic_unit_top.sv
// From accept to done an item passes the multiply states, the Euclid remainder steps and two reductions;
// every divider pass (Euclid step or reduction) runs on the one shared divider.
// Zero denominator or divide by zero: done straight after accept; zero numerator: done from S_GCD_START.
// Throughput: one item at a time; busy stays high from accept through the done strobe.
// Reset: rst_n asynchronous active low returns the sequencer to idle, busy and done low.
// Results are shown for exactly one cycle with done; the receiver cannot stall.
module rational_arithmetic_unit_top
#(
    parameter int DATA_WIDTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         operation,
    input  logic signed [31:0] a_num,
    input  logic signed [31:0] a_den,
    input  logic signed [31:0] b_num,
    input  logic signed [31:0] b_den,
    output logic               done,
    output logic signed [31:0] result_num,
    output logic [30:0]        result_den,
    output logic [1:0]         status
);

    localparam int W = rau_pkg::WIDE;
    localparam int M = DATA_WIDTH;

    rau_pkg::state_t   state_reg, state_next;
    rau_pkg::div_req_t dreq;
    rau_pkg::div_rsp_t drsp;

    logic [2:0]   op_reg, op_next;
    logic [M-1:0] an_reg, an_next, ad_reg, ad_next;
    logic [M-1:0] bn_reg, bn_next, bd_reg, bd_next;
    logic         sa_reg, sa_next, sb_reg, sb_next;
    logic [W-1:0] p_reg, p_next, q_reg, q_next, d_reg, d_next;
    logic [W-1:0] x_reg, x_next, y_reg, y_next;
    logic [W-1:0] num_reg, num_next, den_reg, den_next;
    logic         neg_reg, neg_next;
    logic         done_reg, done_next;
    logic signed [31:0] rn_reg, rn_next;
    logic [30:0]  rd_reg, rd_next;
    logic [1:0]   st_reg, st_next;

    logic [M-1:0] mag_an, mag_ad, mag_bn, mag_bd;
    logic         neg_an, neg_ad, neg_bn, neg_bd;
    logic [M-1:0] mul_x, mul_y;
    logic [2*M-1:0] mul_full;
    logic [W-1:0] mul_p;
    logic         sq;
    logic [W-1:0] lim;

    // Magnitudes of the low DATA_WIDTH bits of each operand
    always_comb
    begin
        neg_an = a_num[M-1];
        neg_ad = a_den[M-1];
        neg_bn = b_num[M-1];
        neg_bd = b_den[M-1];
        mag_an = neg_an ? (M'(0) - a_num[M-1:0]) : a_num[M-1:0];
        mag_ad = neg_ad ? (M'(0) - a_den[M-1:0]) : a_den[M-1:0];
        mag_bn = neg_bn ? (M'(0) - b_num[M-1:0]) : b_num[M-1:0];
        mag_bd = neg_bd ? (M'(0) - b_den[M-1:0]) : b_den[M-1:0];
    end

    // Shared multiplier, one product per cycle
    assign mul_full = mul_x * mul_y;
    assign mul_p = W'(mul_full);
    assign sq    = (op_reg == rau_pkg::OP_SUB) ? !sb_reg : sb_reg;
    assign lim   = W'(1) << (M - 1);

    rau_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        an_next = an_reg; ad_next = ad_reg; bn_next = bn_reg; bd_next = bd_reg;
        sa_next = sa_reg; sb_next = sb_reg;
        p_next = p_reg; q_next = q_reg; d_next = d_reg;
        x_next = x_reg; y_next = y_reg;
        num_next = num_reg; den_next = den_reg; neg_next = neg_reg;
        rn_next = rn_reg; rd_next = rd_reg; st_next = st_reg;
        done_next = 1'b0;
        dreq.start = 1'b0;
        dreq.dividend = x_reg;
        dreq.divisor = y_reg;
        mul_x = an_reg;
        mul_y = bd_reg;
        case (state_reg)
            rau_pkg::S_IDLE:
            begin
                // no accept while the previous done strobe is still out
                if (start && !done_reg)
                begin
                    op_next = operation;
                    an_next = mag_an; ad_next = mag_ad;
                    bn_next = mag_bn; bd_next = mag_bd;
                    sa_next = neg_an != neg_ad;
                    sb_next = neg_bn != neg_bd;
                    if (mag_ad == '0 || (operation <= rau_pkg::OP_DIV && mag_bd == '0)
                        || (operation == rau_pkg::OP_DIV && mag_bn == '0))
                    begin
                        rn_next = '0; rd_next = '0; st_next = rau_pkg::ST_ZERO;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        state_next = rau_pkg::S_MUL1;
                    end
                end
            end
            rau_pkg::S_MUL1:
            begin
                // an*bd, or an*bn for multiply
                mul_x = an_reg;
                mul_y = (op_reg == rau_pkg::OP_MUL) ? bn_reg : bd_reg;
                p_next = mul_p;
                state_next = rau_pkg::S_MUL2;
            end
            rau_pkg::S_MUL2:
            begin
                mul_x = ad_reg;
                mul_y = (op_reg == rau_pkg::OP_DIV) ? bn_reg : bd_reg;
                d_next = mul_p;
                state_next = rau_pkg::S_MUL3;
            end
            rau_pkg::S_MUL3:
            begin
                mul_x = bn_reg;
                mul_y = ad_reg;
                q_next = mul_p;
                state_next = rau_pkg::S_COMB;
            end
            rau_pkg::S_COMB:
            begin
                case (op_reg)
                    rau_pkg::OP_ADD, rau_pkg::OP_SUB:
                    begin
                        if (sa_reg == sq)
                        begin
                            num_next = p_reg + q_reg; neg_next = sa_reg;
                        end
                        else if (p_reg >= q_reg)
                        begin
                            num_next = p_reg - q_reg; neg_next = sa_reg;
                        end
                        else
                        begin
                            num_next = q_reg - p_reg; neg_next = sq;
                        end
                        den_next = d_reg;
                    end
                    rau_pkg::OP_MUL, rau_pkg::OP_DIV:
                    begin
                        num_next = p_reg; den_next = d_reg; neg_next = sa_reg != sb_reg;
                    end
                    default:
                    begin
                        num_next = W'(an_reg); den_next = W'(ad_reg); neg_next = sa_reg;
                    end
                endcase
                state_next = rau_pkg::S_GCD_START;
            end
            rau_pkg::S_GCD_START:
            begin
                if (num_reg == '0)
                begin
                    rn_next = '0; rd_next = 31'd1; st_next = rau_pkg::ST_OK;
                    done_next = 1'b1;
                    state_next = rau_pkg::S_IDLE;
                end
                else
                begin
                    x_next = num_reg; y_next = den_reg;
                    state_next = rau_pkg::S_GCD_STEP;
                end
            end
            rau_pkg::S_GCD_STEP:
            begin
                // y holds the next divisor; zero means x is the gcd
                if (y_reg == '0)
                begin
                    dreq.start = 1'b1;
                    dreq.dividend = num_reg;
                    dreq.divisor = x_reg;
                    state_next = rau_pkg::S_RED_NUM;
                end
                else
                begin
                    dreq.start = 1'b1;
                    state_next = rau_pkg::S_GCD_DIV;
                end
            end
            rau_pkg::S_GCD_DIV:
            begin
                if (drsp.done)
                begin
                    x_next = y_reg;
                    y_next = drsp.remainder;
                    state_next = rau_pkg::S_GCD_STEP;
                end
            end
            rau_pkg::S_RED_NUM:
            begin
                if (drsp.done)
                begin
                    num_next = drsp.quotient;
                    dreq.start = 1'b1;
                    dreq.dividend = den_reg;
                    dreq.divisor = x_reg;
                    state_next = rau_pkg::S_RED_DEN;
                end
            end
            rau_pkg::S_RED_DEN:
            begin
                if (drsp.done)
                begin
                    den_next = drsp.quotient;
                    state_next = rau_pkg::S_CHECK;
                end
            end
            rau_pkg::S_CHECK:
            begin
                if (den_reg > lim - W'(1) || (neg_reg ? num_reg > lim : num_reg > lim - W'(1)))
                begin
                    rn_next = '0; rd_next = '0; st_next = rau_pkg::ST_OVF;
                end
                else
                begin
                    rn_next = neg_reg ? (32'd0 - num_reg[31:0]) : num_reg[31:0];
                    rd_next = den_reg[30:0];
                    st_next = rau_pkg::ST_OK;
                end
                done_next = 1'b1;
                state_next = rau_pkg::S_IDLE;
            end
            default:
            begin
                state_next = rau_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rau_pkg::S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        an_reg <= an_next; ad_reg <= ad_next; bn_reg <= bn_next; bd_reg <= bd_next;
        sa_reg <= sa_next; sb_reg <= sb_next;
        p_reg <= p_next; q_reg <= q_next; d_reg <= d_next;
        x_reg <= x_next; y_reg <= y_next;
        num_reg <= num_next; den_reg <= den_next; neg_reg <= neg_next;
        rn_reg <= rn_next; rd_reg <= rd_next; st_reg <= st_next;
    end

    assign busy       = (state_reg != rau_pkg::S_IDLE) || done_reg;
    assign done       = done_reg;
    assign result_num = rn_reg;
    assign result_den = rd_reg;
    assign status     = st_reg;

endmodule
